>>> hw/rtl/channel_frame_serializer_macros.svh
// Assertion macros for the channel frame serializer.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef CHANNEL_FRAME_SERIALIZER_MACROS_SVH
`define CHANNEL_FRAME_SERIALIZER_MACROS_SVH
`ifndef SYNTH
// Condition implies consequence in the same cycle.
`define CFS_ASSERT_SAME(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Condition implies consequence in the next cycle.
`define CFS_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define CFS_ASSERT_SAME(lbl, cond, cons, msg)
`define CFS_ASSERT_NEXT(lbl, cond, cons, msg)
`endif
`endif

>>> hw/rtl/cfs_pkg.sv
// Shared constants and types for the channel frame serializer.
// No dependencies; used by the controller, datapath and top level.
package cfs_pkg;

    // Table size and derived widths
    localparam int NUM_CHANNELS = 16;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

    // Field widths fixed by the interface
    localparam int CFG_W    = 5;
    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [CFG_W-1:0]  NUM_CH_CFG = CFG_W'(NUM_CHANNELS);

    // Frame header bytes
    localparam logic [BYTE_W-1:0] HDR_A = 8'd251;
    localparam logic [BYTE_W-1:0] HDR_B = 8'd109;
    localparam logic [BYTE_W-1:0] HDR_C = 8'd37;

    // Source of the byte emitted in a cycle
    typedef enum logic [2:0] {
        SEL_HDR_A,
        SEL_HDR_B,
        SEL_HDR_C,
        SEL_HI,
        SEL_LO,
        SEL_SUM
    } sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             store;
        logic             clear_sum;
        logic             emit;
        sel_t             sel;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } sts_t;

endpackage

>>> hw/rtl/cfs_datapath.sv
// Datapath of the channel frame serializer: channel table, config register,
// checksum accumulator and output registers. Depends on cfs_pkg.
module cfs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfs_pkg::cmd_t                  cmd,
    output cfs_pkg::sts_t                  sts,
    input  logic [cfs_pkg::CHAN_W-1:0]     channel,
    input  logic [cfs_pkg::SAMPLE_W-1:0]   sample_value,
    input  logic                           cfg_we,
    input  logic [cfs_pkg::CFG_W-1:0]      cfg_wdata,
    output logic [cfs_pkg::BYTE_W-1:0]     frame_byte,
    output logic                           last_byte,
    output logic                           byte_strobe
);

    logic [cfs_pkg::SAMPLE_W-1:0] table_reg [cfs_pkg::NUM_CHANNELS];
    logic [cfs_pkg::CFG_W-1:0]    cfg_reg;
    logic [cfs_pkg::BYTE_W-1:0]   sum_reg;
    logic [cfs_pkg::BYTE_W-1:0]   byte_reg;
    logic                         last_reg;
    logic                         strobe_reg;

    logic [cfs_pkg::IDX_W-1:0]    wr_idx;
    logic                         wr_ok;
    logic [cfs_pkg::SAMPLE_W-1:0] rd_word;
    logic [cfs_pkg::BYTE_W-1:0]   byte_next;
    logic                         last_next;
    logic [cfs_pkg::BYTE_W-1:0]   sum_next;

    // Decode store address; drop stores past the table
    assign wr_idx = cfs_pkg::IDX_W'(channel);
    assign wr_ok  = ({1'b0, channel} < cfs_pkg::NUM_CH_CFG);

    // Saturate channel count to the table size
    assign sts.count = (cfg_reg > cfs_pkg::NUM_CH_CFG) ? cfs_pkg::CNT_W'(cfs_pkg::NUM_CHANNELS)
                                                       : cfs_pkg::CNT_W'(cfg_reg);

    // Select the byte for this cycle
    assign rd_word = table_reg[cmd.idx];

    always_comb
    begin
        last_next = 1'b0;
        case (cmd.sel)
            cfs_pkg::SEL_HDR_A: byte_next = cfs_pkg::HDR_A;
            cfs_pkg::SEL_HDR_B: byte_next = cfs_pkg::HDR_B;
            cfs_pkg::SEL_HDR_C: byte_next = cfs_pkg::HDR_C;
            cfs_pkg::SEL_HI:    byte_next = rd_word[cfs_pkg::SAMPLE_W-1:cfs_pkg::BYTE_W];
            cfs_pkg::SEL_LO:    byte_next = rd_word[cfs_pkg::BYTE_W-1:0];
            cfs_pkg::SEL_SUM:
            begin
                byte_next = sum_reg;
                last_next = 1'b1;
            end
            default:            byte_next = '0;
        endcase
    end

    // Accumulate the checksum over all bytes before the last
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.clear_sum)
            sum_next = '0;
        else if (cmd.emit && !last_next)
            sum_next = sum_reg + byte_next;
    end

    // Hold the channel table; cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cfs_pkg::NUM_CHANNELS; i++)
                table_reg[i] <= '0;
        end
        else if (cmd.store && wr_ok)
        begin
            table_reg[wr_idx] <= sample_value;
        end
    end

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= cfs_pkg::CFG_RESET;
        else if (cfg_we)
            cfg_reg <= cfg_wdata;
    end

    // Advance checksum and output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            strobe_reg <= cmd.emit;
        end
    end

    // Register output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next && cmd.emit;
    end

    assign frame_byte  = byte_reg;
    assign last_byte   = last_reg;
    assign byte_strobe = strobe_reg;

endmodule

>>> hw/rtl/cfs_controller.sv
// Controller of the channel frame serializer: accepts requests and sequences
// the bytes of a frame. Depends on cfs_pkg.
module cfs_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          mode,
    output logic          busy,
    input  cfs_pkg::sts_t sts,
    output cfs_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_A,
        S_HDR_B,
        S_HDR_C,
        S_HI,
        S_LO,
        S_SUM
    } state_t;

    state_t                    state_reg, state_next;
    logic [cfs_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [cfs_pkg::CNT_W-1:0] idx_inc;
    logic                      accept;

    assign accept  = start && (state_reg == S_IDLE);
    assign idx_inc = idx_reg + cfs_pkg::CNT_W'(1);
    assign busy    = (state_reg != S_IDLE);

    // Issue commands for the current state
    always_comb
    begin
        cmd.store     = accept && !mode;
        cmd.clear_sum = accept && mode;
        cmd.emit      = (state_reg != S_IDLE);
        cmd.idx       = idx_reg[cfs_pkg::IDX_W-1:0];
        case (state_reg)
            S_HDR_A: cmd.sel = cfs_pkg::SEL_HDR_A;
            S_HDR_B: cmd.sel = cfs_pkg::SEL_HDR_B;
            S_HDR_C: cmd.sel = cfs_pkg::SEL_HDR_C;
            S_HI:    cmd.sel = cfs_pkg::SEL_HI;
            S_LO:    cmd.sel = cfs_pkg::SEL_LO;
            S_SUM:   cmd.sel = cfs_pkg::SEL_SUM;
            default: cmd.sel = cfs_pkg::SEL_HDR_A;
        endcase
    end

    // Step through header, channel words and checksum
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode)
                    state_next = S_HDR_A;
            end
            S_HDR_A: state_next = S_HDR_B;
            S_HDR_B: state_next = S_HDR_C;
            S_HDR_C:
            begin
                idx_next   = '0;
                state_next = (sts.count == '0) ? S_SUM : S_HI;
            end
            S_HI:    state_next = S_LO;
            S_LO:
            begin
                idx_next   = idx_inc;
                state_next = (idx_inc == sts.count) ? S_SUM : S_HI;
            end
            S_SUM:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and channel index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> hw/rtl/channel_frame_serializer.sv
// Channel frame serializer: a store request (mode 0) writes one 16-bit
// channel word and busy stays low, so stores may come every cycle while no
// send is running. A send request (mode 1) raises busy while the byte
// sequencer walks header, table and checksum at one byte per cycle, over as
// many channel words as the config register holds, saturated to table size.
// Each byte appears on frame_byte with byte_strobe high for exactly one cycle,
// in the cycle after the sequencer issues it, so the final checksum byte
// (last_byte high) shows in the first cycle with busy low. The receiver cannot
// stall: it must take every strobed byte. Write cfg_wdata only while idle.
// Depends on cfs_pkg, cfs_controller, cfs_datapath and the macro header.
`include "channel_frame_serializer_macros.svh"

module channel_frame_serializer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [cfs_pkg::CHAN_W-1:0]     channel,
    input  logic [cfs_pkg::SAMPLE_W-1:0]   sample_value,
    input  logic                           cfg_we,
    input  logic [cfs_pkg::CFG_W-1:0]      cfg_wdata,
    output logic [cfs_pkg::BYTE_W-1:0]     frame_byte,
    output logic                           last_byte,
    output logic                           byte_strobe
);

    cfs_pkg::cmd_t cmd;
    cfs_pkg::sts_t sts;

    // Sequence requests and frame bytes
    cfs_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Store words, build bytes and checksum
    cfs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .channel      (channel),
        .sample_value (sample_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .byte_strobe  (byte_strobe)
    );

    // Check frame framing against the request handshake
    `CFS_ASSERT_NEXT(a_send_goes_busy, start && !busy && mode, busy, "send did not start")
    `CFS_ASSERT_NEXT(a_idle_no_byte, !busy, !byte_strobe, "byte emitted while idle")
    `CFS_ASSERT_NEXT(a_gap_after_last, byte_strobe && last_byte, !byte_strobe, "no gap after frame")
    `CFS_ASSERT_SAME(a_no_store_busy, cmd.store, !busy, "store taken while busy")

endmodule
